>>> hw/rtl/lruk_pkg.sv
`default_nettype none

package lruk_pkg;

    // Fixed field widths of the transaction ports.
    localparam int ID_W       = 16;
    localparam int COUNT_W    = 16;
    localparam int STAMP_IN_W = 48;

    // Capacity register value after reset.
    localparam logic [COUNT_W-1:0] CAP_RESET = 16'd256;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SELECT = 64;
    localparam int DEF_STAMP_BITS = 48;

    // Direction of the current sift step.
    localparam logic MODE_UP   = 1'b0;
    localparam logic MODE_DOWN = 1'b1;

    // Decision of one sift step, handed from the compare unit to the sequencer.
    typedef struct packed {
        logic move;    // the moving entry passes the slot it is compared against
        logic pick_b;  // the right child is the larger one
    } step_t;

endpackage

`default_nettype wire

>>> hw/rtl/lruk_heap_mem.sv
`default_nettype none

module lruk_heap_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 64
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [W-1:0]  wr_data,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output logic      [W-1:0]  rd_data_a,
    output logic      [W-1:0]  rd_data_b
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Both read ports are registered.
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

>>> hw/rtl/lruk_cmp.sv
`default_nettype none

module lruk_cmp #(
    parameter int SW = 48
) (
    input  wire logic          mode,
    input  wire logic          a_ok,
    input  wire logic          b_ok,
    input  wire logic [SW-1:0] key,
    input  wire logic [SW-1:0] a_stamp,
    input  wire logic [SW-1:0] b_stamp,
    output lruk_pkg::step_t    step
);

    logic          pick_b;
    logic [SW-1:0] sel_stamp;
    logic [SW-1:0] lhs;
    logic [SW-1:0] rhs;

    // On the way down the larger child is chosen first; ties keep the left one.
    assign pick_b    = (mode == lruk_pkg::MODE_DOWN) && b_ok && (a_stamp < b_stamp);
    assign sel_stamp = pick_b ? b_stamp : a_stamp;

    // The one main comparator: parent < key going up, key < child going down.
    assign lhs = (mode == lruk_pkg::MODE_DOWN) ? key : a_stamp;
    assign rhs = (mode == lruk_pkg::MODE_DOWN) ? sel_stamp : key;

    assign step.move   = a_ok && (lhs < rhs);
    assign step.pick_b = pick_b;

endmodule

`default_nettype wire

>>> hw/rtl/lru_eviction_oldest_k_select_core.sv
`default_nettype none
// A begin transaction, or an entry that leaves the heap untouched, is taken while busy stays low.
// A stored entry keeps busy high while it sifts through the heap level by level. A final entry
// then also emits every filled slot; results follow one per cycle, the first in the cycle after
// emission starts; the receiver cannot stall them. Reset (rst_n low, asynchronous) closes any pass,
// empties the heap and sets capacity to 256; the heap memory itself is not cleared.

module lru_eviction_oldest_k_select_core #(
    parameter int MAX_SELECT = lruk_pkg::DEF_MAX_SELECT,
    parameter int STAMP_BITS = lruk_pkg::DEF_STAMP_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lruk_pkg::COUNT_W-1:0]    cfg_wdata,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            op,
    input  wire logic [lruk_pkg::COUNT_W-1:0]    entry_count,
    input  wire logic [lruk_pkg::ID_W-1:0]       entry_id,
    input  wire logic [lruk_pkg::STAMP_IN_W-1:0] stamp,
    input  wire logic                            final_entry,
    output logic                                 result_valid,
    output logic [lruk_pkg::ID_W-1:0]            evict_id,
    output logic [lruk_pkg::STAMP_IN_W-1:0]      evict_stamp,
    output logic                                 run_end
);

    // Address width of the heap, width of the fill and target counters, and the
    // width needed to hold a child index of the deepest slot.
    localparam int AW = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;
    localparam int CW = $clog2(MAX_SELECT + 1);
    localparam int PW = AW + 2;
    localparam int SW = STAMP_BITS;
    localparam int EW = lruk_pkg::ID_W + SW;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UP   = 2'd1;
    localparam logic [1:0] ST_DOWN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [lruk_pkg::COUNT_W-1:0] cap_reg;
    logic [CW-1:0]                target_reg, target_next;
    logic [CW-1:0]                fill_reg, fill_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [EW-1:0]                cur_reg, cur_next;
    logic                         final_reg, final_next;
    logic [SW-1:0]                root_reg;
    logic [CW-1:0]                emit_idx_reg, emit_idx_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_last_reg, out_last_next;

    logic          accept;
    logic [63:0]   stamp_wide;
    logic [SW-1:0] in_stamp;
    logic [EW-1:0] in_entry;
    logic [lruk_pkg::COUNT_W-1:0] excess;
    logic [CW-1:0] begin_target;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [EW-1:0] rd_data_a, rd_data_b;

    logic [PW-1:0] lchild_pos, rchild_pos;
    logic [PW-1:0] issue_left, issue_right;
    logic [AW-1:0] parent_pos, issue_parent;
    logic          left_ok, right_ok;
    logic          step_mode;
    logic          step_a_ok;
    lruk_pkg::step_t step;
    logic [63:0]   out_stamp_wide;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Only the low STAMP_BITS bits of an incoming stamp are kept.
    assign stamp_wide = 64'(stamp);
    assign in_stamp   = stamp_wide[SW-1:0];
    assign in_entry   = {entry_id, in_stamp};

    // Entries beyond capacity, capped at the heap depth.
    always_comb
    begin
        excess = '0;
        if (entry_count > cap_reg)
        begin
            excess = entry_count - cap_reg;
        end
        if (excess > lruk_pkg::COUNT_W'(MAX_SELECT))
        begin
            begin_target = CW'(MAX_SELECT);
        end
        else
        begin
            begin_target = excess[CW-1:0];
        end
    end

    // Neighbours of the slot being worked on.
    assign lchild_pos = {1'b0, pos_reg, 1'b1};
    assign rchild_pos = lchild_pos + PW'(1);
    assign left_ok    = lchild_pos < PW'(fill_reg);
    assign right_ok   = rchild_pos < PW'(fill_reg);
    assign parent_pos = (pos_reg - AW'(1)) >> 1;

    // Addresses to fetch for the slot that the next step will look at.
    assign issue_left   = {1'b0, pos_next, 1'b1};
    assign issue_right  = issue_left + PW'(1);
    assign issue_parent = (pos_next - AW'(1)) >> 1;

    assign step_mode = (state_reg == ST_DOWN) ? lruk_pkg::MODE_DOWN : lruk_pkg::MODE_UP;
    assign step_a_ok = (state_reg == ST_DOWN) ? left_ok : (pos_reg != '0);

    lruk_cmp #(
        .SW (SW)
    ) u_cmp (
        .mode    (step_mode),
        .a_ok    (step_a_ok),
        .b_ok    (right_ok),
        .key     (cur_reg[SW-1:0]),
        .a_stamp (rd_data_a[SW-1:0]),
        .b_stamp (rd_data_b[SW-1:0]),
        .step    (step)
    );

    // Sequencer. Sifting keeps the moving entry in cur_reg and writes each displaced
    // slot one level over, so every level costs one write.
    always_comb
    begin
        state_next     = state_reg;
        target_next    = target_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        final_next     = final_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = 1'b0;
        out_last_next  = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == 1'b0)
                    begin
                        target_next = begin_target;
                        fill_next   = '0;
                    end
                    else if (target_reg != '0)
                    begin
                        final_next = final_entry;
                        if (fill_reg < target_reg)
                        begin
                            // Append at the end and sift up.
                            cur_next   = in_entry;
                            pos_next   = fill_reg[AW-1:0];
                            fill_next  = fill_reg + CW'(1);
                            state_next = ST_UP;
                        end
                        else if (in_stamp < root_reg)
                        begin
                            // Replace the root and sift down.
                            cur_next   = in_entry;
                            pos_next   = '0;
                            state_next = ST_DOWN;
                        end
                        else if (final_entry)
                        begin
                            emit_idx_next = '0;
                            state_next    = ST_EMIT;
                        end
                    end
                end
            end

            ST_UP:
            begin
                wr_en = 1'b1;
                if (step.move)
                begin
                    wr_data  = rd_data_a;
                    pos_next = parent_pos;
                end
                else
                begin
                    state_next    = final_reg ? ST_EMIT : ST_IDLE;
                    emit_idx_next = '0;
                end
            end

            ST_DOWN:
            begin
                wr_en = 1'b1;
                if (step.move)
                begin
                    wr_data  = step.pick_b ? rd_data_b : rd_data_a;
                    pos_next = step.pick_b ? rchild_pos[AW-1:0] : lchild_pos[AW-1:0];
                end
                else
                begin
                    state_next    = final_reg ? ST_EMIT : ST_IDLE;
                    emit_idx_next = '0;
                end
            end

            ST_EMIT:
            begin
                out_valid_next = 1'b1;
                emit_idx_next  = emit_idx_reg + CW'(1);
                if (({1'b0, emit_idx_reg} + (CW + 1)'(1)) == {1'b0, fill_reg})
                begin
                    out_last_next = 1'b1;
                    fill_next     = '0;
                    target_next   = '0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_EMIT)
        begin
            rd_addr_a = emit_idx_reg[AW-1:0];
        end
        else if (state_next == ST_DOWN)
        begin
            rd_addr_a = issue_left[AW-1:0];
        end
        else
        begin
            rd_addr_a = issue_parent;
        end
    end

    assign rd_addr_b = issue_right[AW-1:0];

    lruk_heap_mem #(
        .DEPTH (MAX_SELECT),
        .AW    (AW),
        .W     (EW)
    ) u_heap (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= lruk_pkg::CAP_RESET;
            target_reg    <= '0;
            fill_reg      <= '0;
            emit_idx_reg  <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            fill_reg      <= fill_next;
            emit_idx_reg  <= emit_idx_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers. The root stamp is shadowed here so that the replace
    // decision can be taken in the cycle the transaction arrives.
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        cur_reg <= cur_next;
        if (wr_en && (wr_addr == '0))
        begin
            root_reg <= wr_data[SW-1:0];
        end
    end

    // Results come straight from the registered read port of the heap.
    assign out_stamp_wide = 64'(rd_data_a[SW-1:0]);
    assign result_valid   = out_valid_reg;
    assign run_end        = out_last_reg;
    assign evict_id       = rd_data_a[EW-1:SW];
    assign evict_stamp    = out_stamp_wide[lruk_pkg::STAMP_IN_W-1:0];

    // The heap never holds more slots than the target of the pass.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= target_reg)
        else $error("heap fill exceeds pass target");

    // The target never exceeds the heap depth.
    assert property (@(posedge clk) disable iff (!rst_n) target_reg <= CW'(MAX_SELECT))
        else $error("pass target exceeds heap depth");

    // The sequencer only works while a pass is open.
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> (target_reg != '0))
        else $error("sequencer busy without an open pass");

    // A result only follows a cycle of emission.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result strobe outside emission");

    // The end marker closes the pass: no pass is left open after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_end |-> (result_valid && $past(state_next == ST_IDLE)))
        else $error("end marker without closing the pass");

endmodule

`default_nettype wire
